FILE: design/phsl_pkg.sv
// Package with the constants and types shared by the header snap length block.
`default_nettype none
package phsl_pkg;

  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned ETH_HDR_LEN  = 14;
  localparam int unsigned IPV4_MIN_LEN = 20;
  localparam int unsigned IPV6_HDR_LEN = 40;
  localparam int unsigned TCP_MIN_LEN  = 20;
  localparam int unsigned SMALL_L4_LEN = 8;
  localparam int unsigned TCP_OFF_POS  = 12;
  localparam int unsigned ET_HI_POS    = 12;
  localparam int unsigned ET_LO_POS    = 13;
  localparam int unsigned IP_VER_POS   = 14;
  localparam int unsigned V4_PROTO_POS = 23;
  localparam int unsigned V6_NEXT_POS  = 20;

  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86DD;
  localparam logic [7:0]  PR_ICMP   = 8'd1;
  localparam logic [7:0]  PR_TCP    = 8'd6;
  localparam logic [7:0]  PR_UDP    = 8'd17;
  localparam logic [7:0]  PR_ICMPV6 = 8'd58;

  typedef struct packed {
    logic [15:0] new_length;
    logic        truncated;
  } snap_result_t;

endpackage
`default_nettype wire

FILE: design/phsl_parse.sv
// Per-frame capture state and the snap length decision for one byte.
`default_nettype none
module phsl_parse (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            packet_byte,
  input  wire logic                  last_byte,
  output phsl_pkg::snap_result_t     result
);
  import phsl_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] ether_type;
  logic [6:0]  ip_header_bytes;
  logic [7:0]  l4_protocol;
  logic [6:0]  tcp_header_bytes;

  logic [15:0] byte_count_next;
  logic [15:0] ether_type_next;
  logic [6:0]  ip_header_bytes_next;
  logic [7:0]  l4_protocol_next;
  logic [6:0]  tcp_header_bytes_next;

  logic        is_v4;
  logic        is_v6;
  logic [15:0] tcp_pos;
  logic [15:0] snap;
  logic [15:0] tcp_min;
  logic [6:0]  l4_len;
  logic        l4_known;

  // Capture: the offset of this byte is the count before it.
  always_comb begin
    ether_type_next = ether_type;
    if (byte_count == 16'(ET_HI_POS)) begin
      ether_type_next = {packet_byte, ether_type[7:0]};
    end else if (byte_count == 16'(ET_LO_POS)) begin
      ether_type_next = {ether_type[15:8], packet_byte};
    end
    is_v4 = (ether_type_next == ET_IPV4);
    is_v6 = (ether_type_next == ET_IPV6);

    ip_header_bytes_next = ip_header_bytes;
    l4_protocol_next     = l4_protocol;
    if (is_v4) begin
      if (byte_count == 16'(IP_VER_POS)) begin
        ip_header_bytes_next = 7'(32'(packet_byte[3:0]) * WORD_BYTES);
      end
      if (byte_count == 16'(V4_PROTO_POS)) begin
        l4_protocol_next = packet_byte;
      end
    end else if (is_v6) begin
      if (byte_count == 16'(IP_VER_POS)) begin
        ip_header_bytes_next = 7'(IPV6_HDR_LEN);
      end
      if (byte_count == 16'(V6_NEXT_POS)) begin
        l4_protocol_next = packet_byte;
      end
    end

    tcp_pos = 16'(ETH_HDR_LEN + TCP_OFF_POS) + 16'(ip_header_bytes_next);
    tcp_header_bytes_next = tcp_header_bytes;
    if ((is_v4 || is_v6) && byte_count > 16'(V4_PROTO_POS) &&
        l4_protocol_next == PR_TCP && byte_count == tcp_pos) begin
      tcp_header_bytes_next = 7'(32'(packet_byte[7:4]) * WORD_BYTES);
    end

    byte_count_next = (&byte_count) ? byte_count : byte_count + 16'd1;
  end

  // Decision on the frame total including this byte.
  always_comb begin
    l4_known = 1'b1;
    l4_len   = 7'(SMALL_L4_LEN);
    case (l4_protocol_next)
      PR_ICMP, PR_ICMPV6, PR_UDP: l4_len = 7'(SMALL_L4_LEN);
      PR_TCP:                     l4_len = tcp_header_bytes_next;
      default:                    l4_known = 1'b0;
    endcase

    snap    = 16'(ETH_HDR_LEN) + 16'(ip_header_bytes_next) + 16'(l4_len);
    tcp_min = 16'(ETH_HDR_LEN + TCP_MIN_LEN) + 16'(ip_header_bytes_next);

    result.new_length = byte_count_next;
    result.truncated  = 1'b0;
    if (byte_count_next >= 16'(ETH_HDR_LEN) && l4_known &&
        ((is_v4 && byte_count_next >= 16'(ETH_HDR_LEN + IPV4_MIN_LEN)) ||
         (is_v6 && byte_count_next >= 16'(ETH_HDR_LEN + IPV6_HDR_LEN))) &&
        (l4_protocol_next != PR_TCP || byte_count_next >= tcp_min) &&
        byte_count_next >= snap) begin
      result.new_length = snap;
      result.truncated  = 1'b1;
    end
  end

  // The whole capture state starts over after the final byte of a frame.
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count       <= '0;
      ether_type       <= '0;
      ip_header_bytes  <= '0;
      l4_protocol      <= '0;
      tcp_header_bytes <= '0;
    end else if (step) begin
      byte_count       <= byte_count_next;
      ether_type       <= ether_type_next;
      ip_header_bytes  <= ip_header_bytes_next;
      l4_protocol      <= l4_protocol_next;
      tcp_header_bytes <= tcp_header_bytes_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/packet_header_snap_length.sv
// Top level of the header snap length block: input register, parser, result register.
`default_nettype none
// Takes an Ethernet frame one byte per item and, on the final byte, gives one
// result: the length to keep (Ethernet, IP and transport headers) with
// truncated set, or the unchanged frame length with truncated clear. A byte is
// accepted in every cycle unless a final byte waits in the input register on a
// stalled output; its result is then registered in the result register. The
// single set of capture registers in the parser, updated once per byte, sets
// that rate. A waiting result does not hold up bytes that produce no result.
module packet_header_snap_length (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      new_length,
  output logic             truncated
);
  import phsl_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         out_ready;
  logic         s1_go;
  logic         in_take;
  snap_result_t result;

  assign out_ready = !out_valid || !out_stall;
  assign s1_go     = s1_valid && (!s1_last || out_ready);
  assign in_stall  = s1_valid && !s1_go;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= packet_byte;
      s1_last <= last_byte;
    end
  end

  phsl_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_go),
    .packet_byte (s1_byte),
    .last_byte   (s1_last),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_go && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_go && s1_last) begin
      new_length <= result.new_length;
      truncated  <= result.truncated;
    end
  end

endmodule
`default_nettype wire

FILE: design/phsl_checker.sv
// Port-level checks for the header snap length block and their bind.
`default_nettype none
module phsl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] new_length,
  input wire logic        truncated
);

  // A cut frame keeps at least the Ethernet header (a zero-length IPv4 header
  // with a zero TCP data offset), and at most the longest IPv4 and TCP headers.
  a_trunc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> new_length >= 16'd14 && new_length <= 16'd134)
    else $error("truncated length out of range");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_length) && $stable(truncated))
    else $error("stalled result changed");

  // An empty block never pushes back on input.
  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(!in_valid) && $past(!out_valid) |-> !in_stall)
    else $error("input stalled while block was empty");

endmodule

bind packet_header_snap_length phsl_checker u_phsl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .new_length (new_length),
  .truncated  (truncated)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the packet header snap length block.
`timescale 1ns / 1ps

module tb_top;
  import phsl_pkg::*;

  localparam logic [15:0] ET_ARP     = 16'h0806;
  localparam logic [7:0]  PR_HOPOPT  = 8'd0;
  localparam logic [7:0]  PR_ESP     = 8'd50;
  localparam int          QUIET_LIMIT = 3000;
  localparam int          LONG_FRAME  = 70000;

  // Tracks the header capture of the frame in flight and holds the snap
  // lengths still owed by the block, oldest first.
  class snap_length_board;
    logic [15:0]  frame_bytes;
    logic [15:0]  eth_type;
    logic [6:0]   ip_len;
    logic [7:0]   proto;
    logic [6:0]   tcp_len;
    snap_result_t due_snaps[$];
    int           errors;
    int           frames_cut;
    int           frames_whole;

    function new();
      frame_bytes = '0;
      eth_type = '0;
      ip_len = '0;
      proto = '0;
      tcp_len = '0;
      errors = 0;
      frames_cut = 0;
      frames_whole = 0;
    endfunction

    function snap_result_t snap_decision(int total);
      int l4;
      int hdr;
      snap_result_t r;
      r.new_length = 16'(total);
      r.truncated = 1'b0;
      if (total < ETH_HDR_LEN) return r;
      if (eth_type == ET_IPV4) begin
        if (total < ETH_HDR_LEN + IPV4_MIN_LEN) return r;
      end else if (eth_type == ET_IPV6) begin
        if (total < ETH_HDR_LEN + IPV6_HDR_LEN) return r;
      end else begin
        return r;
      end
      if (proto == PR_ICMP || proto == PR_ICMPV6 || proto == PR_UDP) begin
        l4 = SMALL_L4_LEN;
      end else if (proto == PR_TCP) begin
        if (total < ETH_HDR_LEN + int'(ip_len) + TCP_MIN_LEN) return r;
        l4 = int'(tcp_len);
      end else begin
        return r;
      end
      hdr = ETH_HDR_LEN + int'(ip_len) + l4;
      if (total < hdr) return r;
      r.new_length = 16'(hdr);
      r.truncated = 1'b1;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int off;
      snap_result_t r;
      off = int'(frame_bytes);
      if (off == ET_HI_POS) eth_type[15:8] = b;
      else if (off == ET_LO_POS) eth_type[7:0] = b;
      if (eth_type == ET_IPV4) begin
        if (off == IP_VER_POS) ip_len = {1'b0, b[3:0], 2'b00};
        if (off == V4_PROTO_POS) proto = b;
      end else if (eth_type == ET_IPV6) begin
        if (off == IP_VER_POS) ip_len = 7'(IPV6_HDR_LEN);
        if (off == V6_NEXT_POS) proto = b;
      end
      // The data offset sits in the thirteenth byte of the TCP header.
      if ((eth_type == ET_IPV4 || eth_type == ET_IPV6) && off > V4_PROTO_POS &&
          proto == PR_TCP && off == ETH_HDR_LEN + int'(ip_len) + TCP_OFF_POS)
        tcp_len = {1'b0, b[7:4], 2'b00};
      if (frame_bytes != 16'hFFFF) frame_bytes = frame_bytes + 16'd1;
      if (last) begin
        r = snap_decision(int'(frame_bytes));
        due_snaps.push_back(r);
        if (r.truncated) frames_cut++;
        else frames_whole++;
        frame_bytes = '0;
        eth_type = '0;
        ip_len = '0;
        proto = '0;
        tcp_len = '0;
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [15:0] len, logic cut);
      snap_result_t w;
      if (due_snaps.size() == 0) begin
        report_mismatch("unexpected result, new_length", int'(len), -1);
      end else begin
        w = due_snaps.pop_front();
        if (len !== w.new_length) report_mismatch("new_length", int'(len), int'(w.new_length));
        if (cut !== w.truncated) report_mismatch("truncated", int'(cut), int'(w.truncated));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  packet_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] new_length;
  logic        truncated;

  snap_length_board board = new();
  logic [7:0] frame_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_out = 1'b0;
  int bytes_taken = 0;
  int quiet_cycles = 0;

  packet_header_snap_length dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .packet_byte(packet_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_length(new_length),
    .truncated(truncated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_out || ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        board.note_byte(packet_byte, last_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) board.check_result(new_length, truncated);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Header length at which a frame of this shape starts being cut.
  function automatic int header_len(logic [15:0] et, logic [3:0] ihl,
                                    logic [7:0] pr, logic [3:0] doff);
    int ip;
    ip = (et == ET_IPV6) ? 40 : int'(ihl) * 4;
    if (pr == PR_TCP) return 14 + ip + ((int'(doff) * 4 > 20) ? int'(doff) * 4 : 20);
    return 14 + ip + 8;
  endfunction

  function automatic void make_frame(int len, logic [15:0] et, logic [3:0] ihl,
                                     logic [7:0] pr, logic [3:0] doff);
    int tcp_pos;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (len > 12) frame_q[12] = et[15:8];
    if (len > 13) frame_q[13] = et[7:0];
    if (et == ET_IPV4) begin
      tcp_pos = 26 + int'(ihl) * 4;
      if (len > 14) frame_q[14] = {4'h4, ihl};
      if (len > 23) frame_q[23] = pr;
    end else begin
      tcp_pos = 66;
      if (len > 14) frame_q[14] = {4'h6, frame_q[14][3:0]};
      if (len > 20) frame_q[20] = pr;
    end
    if (len > tcp_pos) frame_q[tcp_pos] = {doff, frame_q[tcp_pos][3:0]};
  endfunction

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      packet_byte <= frame_q[i];
      last_byte <= (i == frame_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  task automatic directed(int len, logic [15:0] et, logic [3:0] ihl,
                          logic [7:0] pr, logic [3:0] doff);
    make_frame(len, et, ihl, pr, doff);
    send_frame();
  endtask

  task automatic random_frame();
    int kind;
    int len;
    logic [15:0] et;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] pr;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) ihl = 4'($urandom_range(0, 4));
    else ihl = 4'($urandom_range(5, 15));
    if ($urandom_range(0, 9) == 0) doff = 4'($urandom_range(0, 4));
    else doff = 4'($urandom_range(5, 15));
    case ($urandom_range(0, 4))
      0: pr = PR_ICMP;
      1: pr = PR_TCP;
      2: pr = PR_UDP;
      3: pr = PR_ICMPV6;
      default: pr = 8'($urandom_range(0, 255));
    endcase
    if (kind < 45) et = ET_IPV4;
    else if (kind < 80) et = ET_IPV6;
    else et = 16'($urandom_range(0, 65535));
    // Well-formed frames land close to their cut point, on either side.
    if (kind < 80) begin
      len = header_len(et, ihl, pr, doff) + $urandom_range(0, 16) - $urandom_range(0, 12);
      if (len < 1) len = 1;
    end else begin
      len = $urandom_range(1, 64);
    end
    make_frame(len, et, ihl, pr, doff);
    send_frame();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 14;
          recv_idle = 86;
        end
        1: begin
          send_idle = 86;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (ph == 0) begin
        directed(1, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(13, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(14, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(60, ET_ARP, 4'd5, PR_UDP, 4'd5);
        directed(33, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(42, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(41, ET_IPV4, 4'd5, PR_UDP, 4'd5);
        directed(60, ET_IPV4, 4'd5, PR_ICMP, 4'd5);
        directed(80, ET_IPV4, 4'd5, PR_TCP, 4'd5);
        directed(53, ET_IPV4, 4'd5, PR_TCP, 4'd5);
        directed(134, ET_IPV4, 4'd15, PR_TCP, 4'd15);
        directed(100, ET_IPV4, 4'd15, PR_TCP, 4'd15);
        directed(60, ET_IPV4, 4'd5, PR_TCP, 4'd0);
        directed(70, ET_IPV4, 4'd0, PR_ICMPV6, 4'd5);
        directed(60, ET_IPV4, 4'd1, PR_TCP, 4'd5);
        directed(60, ET_IPV4, 4'd5, PR_ESP, 4'd5);
        directed(53, ET_IPV6, 4'd5, PR_UDP, 4'd5);
        directed(62, ET_IPV6, 4'd5, PR_ICMPV6, 4'd5);
        directed(62, ET_IPV6, 4'd5, PR_UDP, 4'd5);
        directed(61, ET_IPV6, 4'd5, PR_UDP, 4'd5);
        directed(100, ET_IPV6, 4'd5, PR_TCP, 4'd8);
        directed(73, ET_IPV6, 4'd5, PR_TCP, 4'd5);
        directed(100, ET_IPV6, 4'd5, PR_HOPOPT, 4'd5);
      end
      // Hold the result side off long enough that the input backs up.
      if (ph == 2) begin
        fork
          begin
            @(negedge clk);
            hold_out = 1'b1;
            repeat (400) @(negedge clk);
            hold_out = 1'b0;
          end
        join_none
      end
      repeat (16) random_frame();
      if (ph == 2) begin
        // Byte count saturation, once passed whole and once cut.
        directed(LONG_FRAME, ET_ARP, 4'd5, PR_UDP, 4'd5);
        directed(LONG_FRAME, ET_IPV4, 4'd5, PR_UDP, 4'd5);
      end
    end
    in_valid <= 1'b0;
    while (board.due_snaps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d frames in %0d bytes across three handshake pacing phases",
             board.frames_cut + board.frames_whole, bytes_taken);
    $display("%0d frames cut after the transport header, %0d kept at full length",
             board.frames_cut, board.frames_whole);
    if (board.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
design/phsl_pkg.sv
design/phsl_parse.sv
design/packet_header_snap_length.sv
design/phsl_checker.sv
tb/tb_top.sv
